@@ src/mfts_pkg.sv @@
// Shared types and constants of the multilevel feedback thread scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package mfts_pkg;

    localparam int QUANT_W = 14;
    localparam int TICK_W  = 10;
    localparam int WAIT_W  = 26;
    localparam int MS_W    = 32;
    localparam int STAMP_W = 32;

    localparam logic [QUANT_W-1:0] QUANT_HIGH_RST = 14'd100;
    localparam logic [QUANT_W-1:0] QUANT_MID_RST  = 14'd200;
    localparam logic [QUANT_W-1:0] QUANT_LOW_RST  = 14'd300;
    localparam logic [TICK_W-1:0]  TICK_MS_RST    = 10'd10;

    localparam logic [1:0] CFG_QUANT_HIGH = 2'd0;
    localparam logic [1:0] CFG_QUANT_MID  = 2'd1;
    localparam logic [1:0] CFG_QUANT_LOW  = 2'd2;
    localparam logic [1:0] CFG_TICK_MS    = 2'd3;

    localparam logic [2:0] TS_FREE    = 3'd0;
    localparam logic [2:0] TS_READY   = 3'd1;
    localparam logic [2:0] TS_RUNNING = 3'd2;
    localparam logic [2:0] TS_WAITING = 3'd3;
    localparam logic [2:0] TS_TERM    = 3'd4;

    localparam logic [1:0] RS_OK        = 2'd0;
    localparam logic [1:0] RS_FULL      = 2'd1;
    localparam logic [1:0] RS_NO_RUN    = 2'd2;
    localparam logic [1:0] RS_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_CREATE      = 4'd1,
        OP_WAIT_TIME   = 4'd2,
        OP_WAIT_EVENT  = 4'd3,
        OP_SET_EVENT   = 4'd4,
        OP_CANCEL      = 4'd5,
        OP_TEST_CANCEL = 4'd6,
        OP_EXIT        = 4'd7,
        OP_RECLAIM     = 4'd8,
        OP_READ        = 4'd9
    } op_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_TICK_SLOT,
        CMD_TICK_RUN,
        CMD_FREE_SCAN,
        CMD_CREATE,
        CMD_WAIT,
        CMD_EV_SCAN,
        CMD_EV_WAKE,
        CMD_CANCEL,
        CMD_TEST,
        CMD_EXIT,
        CMD_RECLAIM,
        CMD_DISP_SCAN,
        CMD_DISP_COMMIT,
        CMD_READ
    } dp_cmd_t;

    typedef enum logic [1:0] {
        SRC_CNT,
        SRC_TID,
        SRC_RUN,
        SRC_BEST
    } addr_src_t;

    typedef struct packed {
        logic      load;
        dp_cmd_t   cmd;
        addr_src_t src;
        logic      first;
    } dp_ctl_t;

    function automatic logic [MS_W-1:0] sat_add(input logic [MS_W-1:0] x,
                                                input logic [TICK_W-1:0] t);
        logic [MS_W:0] s;
        s = {1'b0, x} + {{(MS_W-TICK_W+1){1'b0}}, t};
        return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ src/mfts_ctrl.sv @@
// Sequencer of the thread scheduler: walks each item through its slot scans and steps.
// Depends on mfts_pkg; drives mfts_dp through a dp_ctl_t command.
`default_nettype none
module mfts_ctrl #(
    parameter int THREAD_SLOTS = 16,
    parameter int SLOT_W = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [3:0]            opcode,
    input  wire logic                  run_valid,
    output mfts_pkg::dp_ctl_t          ctl,
    output logic        [SLOT_W-1:0]   cnt,
    output logic                       busy,
    output logic                       done
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FINAL, S_CHECK, S_DSCAN, S_DCOMMIT, S_READ
    } state_t;

    state_t            state_reg, state_next;
    mfts_pkg::op_t     op_reg, op_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              last;
    logic              load;
    logic              scan_op;

    assign last = (cnt_reg == SLOT_W'(THREAD_SLOTS - 1));
    assign load = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign cnt  = cnt_reg;

    always_comb
    begin
        case (mfts_pkg::op_t'(opcode))
            mfts_pkg::OP_TICK, mfts_pkg::OP_CREATE,
            mfts_pkg::OP_SET_EVENT, mfts_pkg::OP_RECLAIM: scan_op = 1'b1;
            default: scan_op = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ctl.load   = load;
        ctl.cmd    = mfts_pkg::CMD_NONE;
        ctl.src    = mfts_pkg::SRC_CNT;
        ctl.first  = (cnt_reg == '0);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = mfts_pkg::op_t'(opcode);
                    cnt_next   = '0;
                    state_next = scan_op ? S_SCAN : S_FINAL;
                end
            end
            S_SCAN:
            begin
                case (op_reg)
                    mfts_pkg::OP_TICK:      ctl.cmd = mfts_pkg::CMD_TICK_SLOT;
                    mfts_pkg::OP_CREATE:    ctl.cmd = mfts_pkg::CMD_FREE_SCAN;
                    mfts_pkg::OP_SET_EVENT: ctl.cmd = mfts_pkg::CMD_EV_SCAN;
                    mfts_pkg::OP_RECLAIM:   ctl.cmd = mfts_pkg::CMD_RECLAIM;
                    default:                ctl.cmd = mfts_pkg::CMD_NONE;
                endcase
                cnt_next = last ? '0 : cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                case (op_reg)
                    mfts_pkg::OP_TICK:
                    begin
                        ctl.cmd = mfts_pkg::CMD_TICK_RUN;
                        ctl.src = mfts_pkg::SRC_RUN;
                    end
                    mfts_pkg::OP_CREATE:
                    begin
                        ctl.cmd = mfts_pkg::CMD_CREATE;
                        ctl.src = mfts_pkg::SRC_BEST;
                    end
                    mfts_pkg::OP_WAIT_TIME, mfts_pkg::OP_WAIT_EVENT:
                    begin
                        ctl.cmd = mfts_pkg::CMD_WAIT;
                        ctl.src = mfts_pkg::SRC_RUN;
                    end
                    mfts_pkg::OP_SET_EVENT:
                    begin
                        ctl.cmd = mfts_pkg::CMD_EV_WAKE;
                        ctl.src = mfts_pkg::SRC_BEST;
                    end
                    mfts_pkg::OP_CANCEL:
                    begin
                        ctl.cmd = mfts_pkg::CMD_CANCEL;
                        ctl.src = mfts_pkg::SRC_TID;
                    end
                    mfts_pkg::OP_TEST_CANCEL:
                    begin
                        ctl.cmd = mfts_pkg::CMD_TEST;
                        ctl.src = mfts_pkg::SRC_RUN;
                    end
                    mfts_pkg::OP_EXIT:
                    begin
                        ctl.cmd = mfts_pkg::CMD_EXIT;
                        ctl.src = mfts_pkg::SRC_RUN;
                    end
                    default: ctl.cmd = mfts_pkg::CMD_NONE;
                endcase
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cnt_next   = '0;
                state_next = run_valid ? S_READ : S_DSCAN;
            end
            S_DSCAN:
            begin
                ctl.cmd  = mfts_pkg::CMD_DISP_SCAN;
                cnt_next = last ? '0 : cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = S_DCOMMIT;
                end
            end
            S_DCOMMIT:
            begin
                ctl.cmd    = mfts_pkg::CMD_DISP_COMMIT;
                ctl.src    = mfts_pkg::SRC_BEST;
                state_next = S_READ;
            end
            S_READ:
            begin
                ctl.cmd    = mfts_pkg::CMD_READ;
                ctl.src    = mfts_pkg::SRC_TID;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= mfts_pkg::OP_TICK;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

endmodule
`default_nettype wire

@@ src/mfts_dp.sv @@
// Datapath of the thread scheduler: slot table, running thread, order stamps, results.
// Depends on mfts_pkg; one table entry is read and written per cycle at a chosen slot.
`default_nettype none
module mfts_dp #(
    parameter int THREAD_SLOTS = 16,
    parameter int LEVELS = 3,
    parameter int SLOT_W = 4,
    parameter int LVL_W = 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire mfts_pkg::dp_ctl_t                    ctl,
    input  wire logic [SLOT_W-1:0]                    cnt,
    input  wire logic [3:0]                           opcode,
    input  wire logic [3:0]                           thread_id,
    input  wire logic [1:0]                           priority_req,
    input  wire logic                                 defer_cancel,
    input  wire logic [15:0]                          wait_amount,
    input  wire logic [7:0]                           event_num,
    input  wire logic [mfts_pkg::QUANT_W-1:0]         quantum_high,
    input  wire logic [mfts_pkg::QUANT_W-1:0]         quantum_mid,
    input  wire logic [mfts_pkg::QUANT_W-1:0]         quantum_low,
    input  wire logic [mfts_pkg::TICK_W-1:0]          tick_ms,
    output logic                                      run_valid,
    output logic [1:0]                                status,
    output logic [3:0]                                new_thread_id,
    output logic                                      running_valid,
    output logic [3:0]                                running_id,
    output logic                                      woken_valid,
    output logic [3:0]                                woken_id,
    output logic [2:0]                                slot_state,
    output logic [1:0]                                current_level,
    output logic [1:0]                                base_level,
    output logic [mfts_pkg::MS_W-1:0]                 queued_ms,
    output logic [mfts_pkg::MS_W-1:0]                 waited_ms
);

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    // Slot table.
    logic                             used_reg   [THREAD_SLOTS];
    logic [2:0]                       tstat_reg  [THREAD_SLOTS];
    logic [LVL_W-1:0]                 base_reg   [THREAD_SLOTS];
    logic [LVL_W-1:0]                 lvl_reg    [THREAD_SLOTS];
    logic                             defer_reg  [THREAD_SLOTS];
    logic                             pend_reg   [THREAD_SLOTS];
    logic                             timed_reg  [THREAD_SLOTS];
    logic [mfts_pkg::QUANT_W-1:0]     qleft_reg  [THREAD_SLOTS];
    logic [mfts_pkg::WAIT_W-1:0]      wleft_reg  [THREAD_SLOTS];
    logic [7:0]                       event_reg  [THREAD_SLOTS];
    logic [mfts_pkg::MS_W-1:0]        qms_reg    [THREAD_SLOTS];
    logic [mfts_pkg::MS_W-1:0]        wms_reg    [THREAD_SLOTS];
    logic [mfts_pkg::STAMP_W-1:0]     stamp_reg  [THREAD_SLOTS];

    // Latched item fields.
    mfts_pkg::op_t                    op_reg;
    logic [3:0]                       tid_reg;
    logic [1:0]                       prio_reg;
    logic                             cmode_reg;
    logic [15:0]                      amount_reg;
    logic [7:0]                       ev_reg;

    // Global state and scan trackers.
    logic [mfts_pkg::STAMP_W-1:0]     stamp_cnt_reg, stamp_cnt_next;
    logic                             run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0]                run_slot_reg, run_slot_next;
    logic                             found_reg, found_next;
    logic [SLOT_W-1:0]                best_reg, best_next;
    logic [LVL_W-1:0]                 best_lvl_reg, best_lvl_next;
    logic [mfts_pkg::STAMP_W-1:0]     best_age_reg, best_age_next;
    logic [1:0]                       acc_stat_reg, acc_stat_next;
    logic [3:0]                       acc_newid_reg, acc_newid_next;
    logic                             acc_wv_reg, acc_wv_next;
    logic [3:0]                       acc_wid_reg, acc_wid_next;

    // Result registers.
    logic [1:0]                       o_status_reg;
    logic [3:0]                       o_newid_reg;
    logic                             o_rv_reg;
    logic [3:0]                       o_rid_reg;
    logic                             o_wv_reg;
    logic [3:0]                       o_wid_reg;
    logic [2:0]                       o_ts_reg;
    logic [1:0]                       o_cl_reg;
    logic [1:0]                       o_bl_reg;
    logic [mfts_pkg::MS_W-1:0]        o_qms_reg;
    logic [mfts_pkg::MS_W-1:0]        o_wms_reg;

    // Entry at the selected slot: current and next contents.
    logic [SLOT_W-1:0]                a;
    logic                             n_used;
    logic [2:0]                       n_tstat;
    logic [LVL_W-1:0]                 n_base, n_lvl;
    logic                             n_defer, n_pend, n_timed;
    logic [mfts_pkg::QUANT_W-1:0]     n_qleft;
    logic [mfts_pkg::WAIT_W-1:0]      n_wleft;
    logic [7:0]                       n_event;
    logic [mfts_pkg::MS_W-1:0]        n_qms, n_wms;
    logic [mfts_pkg::STAMP_W-1:0]     n_stamp;

    logic [mfts_pkg::STAMP_W-1:0]     age;
    logic                             tid_ok;
    logic                             fresh;
    logic [LVL_W-1:0]                 create_lvl;
    logic [mfts_pkg::WAIT_W-1:0]      wait_ms;
    logic                             read_ok;

    function automatic logic [mfts_pkg::QUANT_W-1:0] quantum_of(input logic [LVL_W-1:0] l,
        input logic [mfts_pkg::QUANT_W-1:0] qh, input logic [mfts_pkg::QUANT_W-1:0] qm,
        input logic [mfts_pkg::QUANT_W-1:0] ql);
        logic [mfts_pkg::QUANT_W-1:0] q;
        if (l == '0)
            q = ql;
        else if (l >= LVL_TOP)
            q = qh;
        else
            q = qm;
        return q;
    endfunction

    always_comb
    begin
        case (ctl.src)
            mfts_pkg::SRC_CNT:  a = cnt;
            mfts_pkg::SRC_TID:  a = SLOT_W'(tid_reg);
            mfts_pkg::SRC_RUN:  a = run_slot_reg;
            mfts_pkg::SRC_BEST: a = best_reg;
            default:            a = cnt;
        endcase
    end

    assign tid_ok     = (32'(tid_reg) < 32'(THREAD_SLOTS));
    assign age        = stamp_cnt_reg - stamp_reg[a];
    assign fresh      = ctl.first || !found_reg;
    assign create_lvl = (32'(prio_reg) > 32'(LEVELS - 1)) ? LVL_TOP : LVL_W'(prio_reg);
    assign wait_ms    = mfts_pkg::WAIT_W'({10'd0, amount_reg} * {16'd0, tick_ms});
    assign read_ok    = tid_ok && used_reg[a];
    assign run_valid  = run_valid_reg;

    always_comb
    begin
        n_used  = used_reg[a];
        n_tstat = tstat_reg[a];
        n_base  = base_reg[a];
        n_lvl   = lvl_reg[a];
        n_defer = defer_reg[a];
        n_pend  = pend_reg[a];
        n_timed = timed_reg[a];
        n_qleft = qleft_reg[a];
        n_wleft = wleft_reg[a];
        n_event = event_reg[a];
        n_qms   = qms_reg[a];
        n_wms   = wms_reg[a];
        n_stamp = stamp_reg[a];

        stamp_cnt_next = stamp_cnt_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_lvl_next  = best_lvl_reg;
        best_age_next  = best_age_reg;
        acc_stat_next  = acc_stat_reg;
        acc_newid_next = acc_newid_reg;
        acc_wv_next    = acc_wv_reg;
        acc_wid_next   = acc_wid_reg;

        case (ctl.cmd)
            mfts_pkg::CMD_TICK_SLOT:
            begin
                if (used_reg[a])
                begin
                    if (tstat_reg[a] == mfts_pkg::TS_READY)
                    begin
                        n_qms = mfts_pkg::sat_add(qms_reg[a], tick_ms);
                    end
                    else if (tstat_reg[a] == mfts_pkg::TS_WAITING)
                    begin
                        n_wms = mfts_pkg::sat_add(wms_reg[a], tick_ms);
                        if (timed_reg[a])
                        begin
                            if (wleft_reg[a] <= mfts_pkg::WAIT_W'(tick_ms))
                            begin
                                n_wleft        = '0;
                                n_tstat        = mfts_pkg::TS_READY;
                                n_stamp        = stamp_cnt_reg;
                                stamp_cnt_next = stamp_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                n_wleft = wleft_reg[a] - mfts_pkg::WAIT_W'(tick_ms);
                            end
                        end
                    end
                end
            end
            mfts_pkg::CMD_TICK_RUN:
            begin
                if (run_valid_reg)
                begin
                    if (qleft_reg[a] <= mfts_pkg::QUANT_W'(tick_ms))
                    begin
                        n_lvl = (lvl_reg[a] != '0) ? lvl_reg[a] - 1'b1 : lvl_reg[a];
                        n_qleft = quantum_of(n_lvl, quantum_high, quantum_mid, quantum_low);
                        n_tstat        = mfts_pkg::TS_READY;
                        n_stamp        = stamp_cnt_reg;
                        stamp_cnt_next = stamp_cnt_reg + 1'b1;
                        run_valid_next = 1'b0;
                    end
                    else
                    begin
                        n_qleft = qleft_reg[a] - mfts_pkg::QUANT_W'(tick_ms);
                    end
                end
            end
            mfts_pkg::CMD_FREE_SCAN:
            begin
                if (ctl.first)
                begin
                    found_next = 1'b0;
                end
                if (fresh && !used_reg[a])
                begin
                    found_next = 1'b1;
                    best_next  = a;
                end
            end
            mfts_pkg::CMD_CREATE:
            begin
                if (!found_reg)
                begin
                    acc_stat_next = mfts_pkg::RS_FULL;
                end
                else
                begin
                    n_used         = 1'b1;
                    n_base         = create_lvl;
                    n_lvl          = create_lvl;
                    n_defer        = cmode_reg;
                    n_pend         = 1'b0;
                    n_timed        = 1'b0;
                    n_qleft = quantum_of(create_lvl, quantum_high, quantum_mid, quantum_low);
                    n_wleft        = '0;
                    n_event        = '0;
                    n_qms          = '0;
                    n_wms          = '0;
                    n_tstat        = mfts_pkg::TS_READY;
                    n_stamp        = stamp_cnt_reg;
                    stamp_cnt_next = stamp_cnt_reg + 1'b1;
                    acc_newid_next = 4'(a);
                end
            end
            mfts_pkg::CMD_WAIT:
            begin
                if (!run_valid_reg)
                begin
                    acc_stat_next = mfts_pkg::RS_NO_RUN;
                end
                else
                begin
                    n_lvl = (lvl_reg[a] < LVL_TOP) ? lvl_reg[a] + 1'b1 : lvl_reg[a];
                    n_qleft = quantum_of(n_lvl, quantum_high, quantum_mid, quantum_low);
                    n_tstat        = mfts_pkg::TS_WAITING;
                    n_timed        = (op_reg == mfts_pkg::OP_WAIT_TIME);
                    n_wleft        = wait_ms;
                    n_event        = ev_reg;
                    n_stamp        = stamp_cnt_reg;
                    stamp_cnt_next = stamp_cnt_reg + 1'b1;
                    run_valid_next = 1'b0;
                end
            end
            mfts_pkg::CMD_EV_SCAN:
            begin
                if (ctl.first)
                begin
                    found_next = 1'b0;
                end
                if (used_reg[a] && tstat_reg[a] == mfts_pkg::TS_WAITING && !timed_reg[a]
                    && event_reg[a] == ev_reg)
                begin
                    if (fresh || lvl_reg[a] > best_lvl_reg ||
                        (lvl_reg[a] == best_lvl_reg && age < best_age_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = a;
                        best_lvl_next = lvl_reg[a];
                        best_age_next = age;
                    end
                end
            end
            mfts_pkg::CMD_EV_WAKE:
            begin
                if (found_reg)
                begin
                    n_tstat        = mfts_pkg::TS_READY;
                    n_stamp        = stamp_cnt_reg;
                    stamp_cnt_next = stamp_cnt_reg + 1'b1;
                    acc_wv_next    = 1'b1;
                    acc_wid_next   = 4'(a);
                end
            end
            mfts_pkg::CMD_CANCEL:
            begin
                if (!tid_ok || !used_reg[a] || (tstat_reg[a] != mfts_pkg::TS_READY &&
                    tstat_reg[a] != mfts_pkg::TS_WAITING))
                begin
                    acc_stat_next = mfts_pkg::RS_NOT_FOUND;
                end
                else if (defer_reg[a])
                begin
                    n_pend = 1'b1;
                end
                else
                begin
                    n_tstat = mfts_pkg::TS_TERM;
                end
            end
            mfts_pkg::CMD_TEST:
            begin
                if (!run_valid_reg)
                begin
                    acc_stat_next = mfts_pkg::RS_NO_RUN;
                end
                else if (pend_reg[a])
                begin
                    n_tstat        = mfts_pkg::TS_TERM;
                    run_valid_next = 1'b0;
                end
            end
            mfts_pkg::CMD_EXIT:
            begin
                if (!run_valid_reg)
                begin
                    acc_stat_next = mfts_pkg::RS_NO_RUN;
                end
                else
                begin
                    n_tstat        = mfts_pkg::TS_TERM;
                    run_valid_next = 1'b0;
                end
            end
            mfts_pkg::CMD_RECLAIM:
            begin
                if (used_reg[a] && tstat_reg[a] == mfts_pkg::TS_TERM)
                begin
                    n_used  = 1'b0;
                    n_tstat = mfts_pkg::TS_FREE;
                end
            end
            mfts_pkg::CMD_DISP_SCAN:
            begin
                if (ctl.first)
                begin
                    found_next = 1'b0;
                end
                if (used_reg[a] && tstat_reg[a] == mfts_pkg::TS_READY)
                begin
                    if (fresh || lvl_reg[a] > best_lvl_reg ||
                        (lvl_reg[a] == best_lvl_reg && age > best_age_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = a;
                        best_lvl_next = lvl_reg[a];
                        best_age_next = age;
                    end
                end
            end
            mfts_pkg::CMD_DISP_COMMIT:
            begin
                if (!run_valid_reg && found_reg)
                begin
                    n_tstat        = mfts_pkg::TS_RUNNING;
                    run_valid_next = 1'b1;
                    run_slot_next  = a;
                end
            end
            default:
            begin
            end
        endcase

        if (ctl.load)
        begin
            acc_stat_next  = mfts_pkg::RS_OK;
            acc_newid_next = '0;
            acc_wv_next    = 1'b0;
            acc_wid_next   = '0;
        end
    end

    // Control state and valid bits of the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                used_reg[i]  <= 1'b0;
                tstat_reg[i] <= mfts_pkg::TS_FREE;
            end
            stamp_cnt_reg <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            used_reg[a]   <= n_used;
            tstat_reg[a]  <= n_tstat;
            stamp_cnt_reg <= stamp_cnt_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            found_reg     <= found_next;
        end
    end

    // Payload: table contents, latched fields, trackers and results.
    always_ff @(posedge clk)
    begin
        base_reg[a]   <= n_base;
        lvl_reg[a]    <= n_lvl;
        defer_reg[a]  <= n_defer;
        pend_reg[a]   <= n_pend;
        timed_reg[a]  <= n_timed;
        qleft_reg[a]  <= n_qleft;
        wleft_reg[a]  <= n_wleft;
        event_reg[a]  <= n_event;
        qms_reg[a]    <= n_qms;
        wms_reg[a]    <= n_wms;
        stamp_reg[a]  <= n_stamp;

        best_reg      <= best_next;
        best_lvl_reg  <= best_lvl_next;
        best_age_reg  <= best_age_next;
        acc_stat_reg  <= acc_stat_next;
        acc_newid_reg <= acc_newid_next;
        acc_wv_reg    <= acc_wv_next;
        acc_wid_reg   <= acc_wid_next;

        if (ctl.load)
        begin
            op_reg     <= mfts_pkg::op_t'(opcode);
            tid_reg    <= thread_id;
            prio_reg   <= priority_req;
            cmode_reg  <= defer_cancel;
            amount_reg <= wait_amount;
            ev_reg     <= event_num;
        end

        if (ctl.cmd == mfts_pkg::CMD_READ)
        begin
            o_newid_reg <= acc_newid_reg;
            o_rv_reg    <= run_valid_reg;
            o_rid_reg   <= run_valid_reg ? 4'(run_slot_reg) : 4'd0;
            o_wv_reg    <= acc_wv_reg;
            o_wid_reg   <= acc_wid_reg;
            o_status_reg <= acc_stat_reg;
            o_ts_reg    <= '0;
            o_cl_reg    <= '0;
            o_bl_reg    <= '0;
            o_qms_reg   <= '0;
            o_wms_reg   <= '0;
            if (op_reg == mfts_pkg::OP_READ)
            begin
                if (!read_ok)
                begin
                    o_status_reg <= mfts_pkg::RS_NOT_FOUND;
                end
                else
                begin
                    o_ts_reg  <= tstat_reg[a];
                    o_cl_reg  <= 2'(lvl_reg[a]);
                    o_bl_reg  <= 2'(base_reg[a]);
                    o_qms_reg <= qms_reg[a];
                    o_wms_reg <= wms_reg[a];
                end
            end
        end
    end

    assign status        = o_status_reg;
    assign new_thread_id = o_newid_reg;
    assign running_valid = o_rv_reg;
    assign running_id    = o_rid_reg;
    assign woken_valid   = o_wv_reg;
    assign woken_id      = o_wid_reg;
    assign slot_state    = o_ts_reg;
    assign current_level = o_cl_reg;
    assign base_level    = o_bl_reg;
    assign queued_ms     = o_qms_reg;
    assign waited_ms     = o_wms_reg;

endmodule
`default_nettype wire

@@ src/multilevel_feedback_thread_scheduler_top.sv @@
// Top level of the multilevel feedback thread scheduler: configuration registers,
// sequencer and datapath. Depends on mfts_pkg, mfts_ctrl and mfts_dp.
//
// Usage: an item (an opcode with its fields) is accepted at a rising edge where
// start is high and busy is low. Busy stays high while the item is processed.
// Exactly one result item comes back per input item: its fields are valid in
// the single cycle in which done is high, and the receiver must take it then,
// since it cannot hold results off. A new item may be started in that cycle.
// The slot table is one register file visited at one slot per cycle.
// Tick, create, set event and reclaim walk all THREAD_SLOTS slots; when no
// thread is running afterwards, the dispatch search walks them again. One item
// is processed at a time. The quantum and tick registers sit on the APB-style
// port, four 32-bit words at byte addresses 0, 4, 8 and 12; the user must see
// that they are written only while the block is idle; the block itself does
// not enforce it. Reset clears the table's valid bits, the order stamp counter
// and the running thread, and loads the register defaults; no clearing pass is
// needed.
`default_nettype none
module multilevel_feedback_thread_scheduler_top #(
    parameter int THREAD_SLOTS = 16,
    parameter int LEVELS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic [3:0]  opcode,
    input  wire logic [3:0]  thread_id,
    input  wire logic [1:0]  priority_req,
    input  wire logic        defer_cancel,
    input  wire logic [15:0] wait_amount,
    input  wire logic [7:0]  event_num,
    output logic [1:0]       status,
    output logic [3:0]       new_thread_id,
    output logic             running_valid,
    output logic [3:0]       running_id,
    output logic             woken_valid,
    output logic [3:0]       woken_id,
    output logic [2:0]       slot_state,
    output logic [1:0]       current_level,
    output logic [1:0]       base_level,
    output logic [31:0]      queued_ms,
    output logic [31:0]      waited_ms,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [mfts_pkg::QUANT_W-1:0] qhigh_reg, qmid_reg, qlow_reg;
    logic [mfts_pkg::TICK_W-1:0]  tick_reg;
    logic                         cfg_wr;
    mfts_pkg::dp_ctl_t            ctl;
    logic [SLOT_W-1:0]            cnt;
    logic                         run_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers; a write keeps the low bits of the word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qhigh_reg <= mfts_pkg::QUANT_HIGH_RST;
            qmid_reg  <= mfts_pkg::QUANT_MID_RST;
            qlow_reg  <= mfts_pkg::QUANT_LOW_RST;
            tick_reg  <= mfts_pkg::TICK_MS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                mfts_pkg::CFG_QUANT_HIGH: qhigh_reg <= pwdata[mfts_pkg::QUANT_W-1:0];
                mfts_pkg::CFG_QUANT_MID:  qmid_reg  <= pwdata[mfts_pkg::QUANT_W-1:0];
                mfts_pkg::CFG_QUANT_LOW:  qlow_reg  <= pwdata[mfts_pkg::QUANT_W-1:0];
                mfts_pkg::CFG_TICK_MS:    tick_reg  <= pwdata[mfts_pkg::TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mfts_pkg::CFG_QUANT_HIGH: prdata = 32'(qhigh_reg);
            mfts_pkg::CFG_QUANT_MID:  prdata = 32'(qmid_reg);
            mfts_pkg::CFG_QUANT_LOW:  prdata = 32'(qlow_reg);
            mfts_pkg::CFG_TICK_MS:    prdata = 32'(tick_reg);
            default:                  prdata = '0;
        endcase
    end

    // The sequencer picks the slot walk and the step for each cycle of an item.
    mfts_ctrl #(
        .THREAD_SLOTS(THREAD_SLOTS),
        .SLOT_W(SLOT_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .opcode(opcode),
        .run_valid(run_valid),
        .ctl(ctl),
        .cnt(cnt),
        .busy(busy),
        .done(done)
    );

    // The datapath holds the thread table and forms the result item.
    mfts_dp #(
        .THREAD_SLOTS(THREAD_SLOTS),
        .LEVELS(LEVELS),
        .SLOT_W(SLOT_W),
        .LVL_W(LVL_W)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .cnt(cnt),
        .opcode(opcode),
        .thread_id(thread_id),
        .priority_req(priority_req),
        .defer_cancel(defer_cancel),
        .wait_amount(wait_amount),
        .event_num(event_num),
        .quantum_high(qhigh_reg),
        .quantum_mid(qmid_reg),
        .quantum_low(qlow_reg),
        .tick_ms(tick_reg),
        .run_valid(run_valid),
        .status(status),
        .new_thread_id(new_thread_id),
        .running_valid(running_valid),
        .running_id(running_id),
        .woken_valid(woken_valid),
        .woken_id(woken_id),
        .slot_state(slot_state),
        .current_level(current_level),
        .base_level(base_level),
        .queued_ms(queued_ms),
        .waited_ms(waited_ms)
    );

endmodule
`default_nettype wire

@@ tb/tb_multilevel_feedback_thread_scheduler_top.sv @@
// Self-checking testbench of the multilevel feedback thread scheduler top level.
// It drives items and APB register writes, predicts every result, and checks it.
// Depends on mfts_pkg and multilevel_feedback_thread_scheduler_top.
`default_nettype none
module tb_multilevel_feedback_thread_scheduler_top;

    localparam int SLOTS = 16;
    localparam int TOP_LVL = 2;

    // One result item as the block reports it.
    typedef struct {
        logic [1:0]  status;
        logic [3:0]  new_thread_id;
        logic        running_valid;
        logic [3:0]  running_id;
        logic        woken_valid;
        logic [3:0]  woken_id;
        logic [2:0]  slot_state;
        logic [1:0]  current_level;
        logic [1:0]  base_level;
        logic [31:0] queued_ms;
        logic [31:0] waited_ms;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [3:0]  opcode;
    logic [3:0]  thread_id;
    logic [1:0]  priority_req;
    logic        defer_cancel;
    logic [15:0] wait_amount;
    logic [7:0]  event_num;
    logic [1:0]  status;
    logic [3:0]  new_thread_id;
    logic        running_valid;
    logic [3:0]  running_id;
    logic        woken_valid;
    logic [3:0]  woken_id;
    logic [2:0]  slot_state;
    logic [1:0]  current_level;
    logic [1:0]  base_level;
    logic [31:0] queued_ms;
    logic [31:0] waited_ms;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multilevel_feedback_thread_scheduler_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .opcode(opcode), .thread_id(thread_id), .priority_req(priority_req),
        .defer_cancel(defer_cancel), .wait_amount(wait_amount), .event_num(event_num),
        .status(status), .new_thread_id(new_thread_id),
        .running_valid(running_valid), .running_id(running_id),
        .woken_valid(woken_valid), .woken_id(woken_id),
        .slot_state(slot_state), .current_level(current_level),
        .base_level(base_level), .queued_ms(queued_ms), .waited_ms(waited_ms),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The clock runs with a period of 10 time units.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the scheduler: register values, the thread table and the
    // running thread, updated as each item is accepted.
    logic [13:0] q_high, q_mid, q_low;
    logic [9:0]  tick_len;
    logic        t_used [SLOTS];
    logic [2:0]  t_state [SLOTS];
    logic [1:0]  t_base [SLOTS];
    logic [1:0]  t_lvl [SLOTS];
    logic        t_defer [SLOTS];
    logic        t_pend [SLOTS];
    logic        t_timed [SLOTS];
    logic [13:0] t_quant [SLOTS];
    logic [25:0] t_wait [SLOTS];
    logic [7:0]  t_event [SLOTS];
    logic [31:0] t_qms [SLOTS];
    logic [31:0] t_wms [SLOTS];
    logic [31:0] t_stamp [SLOTS];
    logic [31:0] order_ctr;
    logic        cpu_busy;
    logic [3:0]  cpu_slot;

    // Results predicted but not yet reported by the block, oldest first.
    sched_result_t pending_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int wakes_seen;
    int creates_full;

    function automatic logic [13:0] slice_of(input logic [1:0] lvl);
        if (lvl == 2'd0)
            return q_low;
        if (lvl >= TOP_LVL)
            return q_high;
        return q_mid;
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] x, input logic [9:0] t);
        logic [32:0] s;
        s = {1'b0, x} + {23'd0, t};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Each entry into ready or waiting takes the next order stamp.
    task automatic enter_ready(input int i);
        t_state[i] = mfts_pkg::TS_READY;
        t_stamp[i] = order_ctr;
        order_ctr = order_ctr + 1;
    endtask

    task automatic run_tick();
        int i;
        int r;
        for (i = 0; i < SLOTS; i++)
        begin
            if (!t_used[i])
                continue;
            if (t_state[i] == mfts_pkg::TS_READY)
                t_qms[i] = add_sat(t_qms[i], tick_len);
            else if (t_state[i] == mfts_pkg::TS_WAITING)
                t_wms[i] = add_sat(t_wms[i], tick_len);
        end
        // Expired timed waiters wake in slot order, before any quantum expiry.
        for (i = 0; i < SLOTS; i++)
        begin
            if (!t_used[i] || t_state[i] != mfts_pkg::TS_WAITING || !t_timed[i])
                continue;
            if (t_wait[i] <= tick_len)
            begin
                t_wait[i] = '0;
                enter_ready(i);
            end
            else
                t_wait[i] = t_wait[i] - tick_len;
        end
        if (cpu_busy)
        begin
            r = cpu_slot;
            if (t_quant[r] <= tick_len)
            begin
                if (t_lvl[r] > 0)
                    t_lvl[r] = t_lvl[r] - 2'd1;
                t_quant[r] = slice_of(t_lvl[r]);
                enter_ready(r);
                cpu_busy = 1'b0;
            end
            else
                t_quant[r] = t_quant[r] - tick_len;
        end
    endtask

    // Oldest ready thread of the highest non-empty level gets the CPU.
    task automatic pick_next();
        int i;
        int best;
        logic [31:0] age, best_age;
        logic found;
        best = 0;
        best_age = '0;
        found = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            if (!t_used[i] || t_state[i] != mfts_pkg::TS_READY)
                continue;
            age = order_ctr - t_stamp[i];
            if (!found || t_lvl[i] > t_lvl[best] ||
                (t_lvl[i] == t_lvl[best] && age > best_age))
            begin
                found = 1'b1;
                best = i;
                best_age = age;
            end
        end
        if (found)
        begin
            t_state[best] = mfts_pkg::TS_RUNNING;
            cpu_busy = 1'b1;
            cpu_slot = best[3:0];
        end
    endtask

    // Works out the result of one accepted item and advances the shadow state.
    task automatic predict_item(input logic [3:0] op, input logic [3:0] tid,
                                input logic [1:0] prio, input logic cmode,
                                input logic [15:0] amt, input logic [7:0] ev,
                                output sched_result_t res);
        int i;
        int best;
        int r;
        logic [31:0] age, best_age;
        logic found;
        logic [1:0] lvl;
        res = '{default: '0};
        case (op)
            mfts_pkg::OP_TICK:
                run_tick();
            mfts_pkg::OP_CREATE:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (!t_used[i])
                        break;
                if (i >= SLOTS)
                begin
                    res.status = mfts_pkg::RS_FULL;
                    creates_full++;
                end
                else
                begin
                    lvl = (prio > TOP_LVL) ? 2'(TOP_LVL) : prio;
                    t_used[i] = 1'b1;
                    t_base[i] = lvl;
                    t_lvl[i] = lvl;
                    t_defer[i] = cmode;
                    t_pend[i] = 1'b0;
                    t_timed[i] = 1'b0;
                    t_quant[i] = slice_of(lvl);
                    t_wait[i] = '0;
                    t_event[i] = '0;
                    t_qms[i] = '0;
                    t_wms[i] = '0;
                    enter_ready(i);
                    res.new_thread_id = i[3:0];
                end
            end
            mfts_pkg::OP_WAIT_TIME, mfts_pkg::OP_WAIT_EVENT:
            begin
                if (!cpu_busy)
                    res.status = mfts_pkg::RS_NO_RUN;
                else
                begin
                    // A waiting thread rises one level, capped at the top.
                    r = cpu_slot;
                    if (t_lvl[r] < TOP_LVL)
                        t_lvl[r] = t_lvl[r] + 2'd1;
                    t_quant[r] = slice_of(t_lvl[r]);
                    t_state[r] = mfts_pkg::TS_WAITING;
                    t_timed[r] = (op == mfts_pkg::OP_WAIT_TIME);
                    t_wait[r] = 26'({16'd0, amt} * {22'd0, tick_len});
                    t_event[r] = ev;
                    t_stamp[r] = order_ctr;
                    order_ctr = order_ctr + 1;
                    cpu_busy = 1'b0;
                end
            end
            mfts_pkg::OP_SET_EVENT:
            begin
                // Highest level first, then the newest waiter on that event.
                best = 0;
                best_age = '0;
                found = 1'b0;
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!t_used[i] || t_state[i] != mfts_pkg::TS_WAITING || t_timed[i] ||
                        t_event[i] != ev)
                        continue;
                    age = order_ctr - t_stamp[i];
                    if (!found || t_lvl[i] > t_lvl[best] ||
                        (t_lvl[i] == t_lvl[best] && age < best_age))
                    begin
                        found = 1'b1;
                        best = i;
                        best_age = age;
                    end
                end
                if (found)
                begin
                    enter_ready(best);
                    res.woken_valid = 1'b1;
                    res.woken_id = best[3:0];
                    wakes_seen++;
                end
            end
            mfts_pkg::OP_CANCEL:
            begin
                if (!t_used[tid] || (t_state[tid] != mfts_pkg::TS_READY &&
                    t_state[tid] != mfts_pkg::TS_WAITING))
                    res.status = mfts_pkg::RS_NOT_FOUND;
                else if (t_defer[tid])
                    t_pend[tid] = 1'b1;
                else
                    t_state[tid] = mfts_pkg::TS_TERM;
            end
            mfts_pkg::OP_TEST_CANCEL:
            begin
                if (!cpu_busy)
                    res.status = mfts_pkg::RS_NO_RUN;
                else if (t_pend[cpu_slot])
                begin
                    t_state[cpu_slot] = mfts_pkg::TS_TERM;
                    cpu_busy = 1'b0;
                end
            end
            mfts_pkg::OP_EXIT:
            begin
                if (!cpu_busy)
                    res.status = mfts_pkg::RS_NO_RUN;
                else
                begin
                    t_state[cpu_slot] = mfts_pkg::TS_TERM;
                    cpu_busy = 1'b0;
                end
            end
            mfts_pkg::OP_RECLAIM:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (t_used[i] && t_state[i] == mfts_pkg::TS_TERM)
                    begin
                        t_used[i] = 1'b0;
                        t_state[i] = mfts_pkg::TS_FREE;
                    end
            end
            default:
            begin
            end
        endcase

        if (!cpu_busy)
            pick_next();

        if (op == mfts_pkg::OP_READ)
        begin
            if (!t_used[tid])
                res.status = mfts_pkg::RS_NOT_FOUND;
            else
            begin
                res.slot_state = t_state[tid];
                res.current_level = t_lvl[tid];
                res.base_level = t_base[tid];
                res.queued_ms = t_qms[tid];
                res.waited_ms = t_wms[tid];
            end
        end
        res.running_valid = cpu_busy;
        res.running_id = cpu_busy ? cpu_slot : 4'd0;
    endtask

    // Sends one item after an idle gap of the given length and records the
    // predicted result at the edge that accepts it. Start is left high so a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_item(input logic [3:0] op, input logic [3:0] tid,
                             input logic [1:0] prio, input logic cmode,
                             input logic [15:0] amt, input logic [7:0] ev,
                             input int gap);
        sched_result_t res;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode <= op;
        thread_id <= tid;
        priority_req <= prio;
        defer_cancel <= cmode;
        wait_amount <= amt;
        event_num <= ev;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_item(op, tid, prio, cmode, amt, ev, res);
        pending_results.push_back(res);
        items_sent++;
    endtask

    // Short-hand for directed items with no gap in front of them.
    task automatic do_op(input logic [3:0] op, input logic [3:0] tid = 4'd0,
                         input logic [1:0] prio = 2'd0, input logic cmode = 1'b0,
                         input logic [15:0] amt = 16'd0, input logic [7:0] ev = 8'd0);
        send_item(op, tid, prio, cmode, amt, ev, 0);
    endtask

    // Lowers start and lets every outstanding result arrive, then waits longer
    // so that the block is surely idle.
    task automatic drain();
        @(posedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle with pready always high.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mfts_pkg::CFG_QUANT_HIGH: q_high = value[13:0];
            mfts_pkg::CFG_QUANT_MID:  q_mid = value[13:0];
            mfts_pkg::CFG_QUANT_LOW:  q_low = value[13:0];
            default:                  tick_len = value[9:0];
        endcase
    endtask

    task automatic set_timing(input int qh, input int qm, input int ql, input int tk);
        drain();
        write_reg(mfts_pkg::CFG_QUANT_HIGH, qh);
        write_reg(mfts_pkg::CFG_QUANT_MID, qm);
        write_reg(mfts_pkg::CFG_QUANT_LOW, ql);
        write_reg(mfts_pkg::CFG_TICK_MS, tk);
        @(posedge clk);
    endtask

    // A tick, a cancel and the ops that need a running thread, with an empty table,
    // plus a read of a free slot, reclaim with nothing to free and the unused opcodes.
    task automatic test_empty_table();
        int op;
        do_op(mfts_pkg::OP_TICK);
        do_op(mfts_pkg::OP_WAIT_TIME, 4'd0, 2'd0, 1'b0, 16'd5);
        do_op(mfts_pkg::OP_WAIT_EVENT, 4'd0, 2'd0, 1'b0, 16'd0, 8'd1);
        do_op(mfts_pkg::OP_TEST_CANCEL);
        do_op(mfts_pkg::OP_EXIT);
        do_op(mfts_pkg::OP_READ, 4'd15);
        do_op(mfts_pkg::OP_CANCEL, 4'd3);
        do_op(mfts_pkg::OP_RECLAIM);
        for (op = 10; op < 16; op++)
            do_op(op[3:0], 4'hF, 2'd3, 1'b1, 16'hFFFF, 8'hFF);
    endtask

    // A walk through a thread's life: creation at every level, waits on time
    // and events, wake-ups, cancels, exit and reclaim.
    task automatic test_lifecycle();
        do_op(mfts_pkg::OP_CREATE, 4'd0, 2'd0, 1'b0);
        do_op(mfts_pkg::OP_CREATE, 4'd0, 2'd1, 1'b1);
        do_op(mfts_pkg::OP_CREATE, 4'd0, 2'd2, 1'b0);
        do_op(mfts_pkg::OP_CREATE, 4'd0, 2'd3, 1'b1);  // level request above the top saturates
        do_op(mfts_pkg::OP_WAIT_TIME, 4'd0, 2'd0, 1'b0, 16'd0);  // zero wait ends next tick
        do_op(mfts_pkg::OP_WAIT_EVENT, 4'd0, 2'd0, 1'b0, 16'd0, 8'hA5);
        do_op(mfts_pkg::OP_WAIT_EVENT, 4'd0, 2'd0, 1'b0, 16'd0, 8'hA5);
        do_op(mfts_pkg::OP_SET_EVENT, 4'd0, 2'd0, 1'b0, 16'd0, 8'h5A); // nobody waits on it
        do_op(mfts_pkg::OP_TICK);
        do_op(mfts_pkg::OP_SET_EVENT, 4'd0, 2'd0, 1'b0, 16'd0, 8'hA5);
        do_op(mfts_pkg::OP_READ, 4'd2);
        do_op(mfts_pkg::OP_CANCEL, 4'd1);                // running, so reported not found
        do_op(mfts_pkg::OP_CANCEL, 4'd0);
        do_op(mfts_pkg::OP_CANCEL, running_slot_guess());
        do_op(mfts_pkg::OP_TEST_CANCEL);
        do_op(mfts_pkg::OP_WAIT_TIME, 4'd0, 2'd0, 1'b0, 16'hFFFF);
        repeat (12) do_op(mfts_pkg::OP_TICK);            // quantum runs out, thread drops a level
        do_op(mfts_pkg::OP_EXIT);
        do_op(mfts_pkg::OP_RECLAIM);
        do_op(mfts_pkg::OP_READ, 4'd0);
    endtask

    function automatic logic [3:0] running_slot_guess();
        return cpu_slot;
    endfunction

    // Creates past the slot count so the table is found full, then cancels, tests for cancel, exits and reclaims.
    task automatic test_table_full();
        int i;
        for (i = 0; i < SLOTS + 1; i++)
            do_op(mfts_pkg::OP_CREATE, 4'd0, i[1:0], i[0]);
        for (i = 0; i < SLOTS; i++)
        begin
            do_op(mfts_pkg::OP_CANCEL, i[3:0]);
            do_op(mfts_pkg::OP_TEST_CANCEL);
            do_op(mfts_pkg::OP_EXIT);
        end
        do_op(mfts_pkg::OP_RECLAIM);
    endtask

    // Random items weighted toward the ops that move threads between states.
    // Events come mostly from a small set so that waiters are found.
    task automatic test_random_mix(input int count, input bit no_idle);
        int n, w, gap;
        logic [3:0] op;
        logic [15:0] amt;
        logic [7:0] ev;
        for (n = 0; n < count; n++)
        begin
            w = $urandom_range(0, 99);
            if (w < 25)      op = mfts_pkg::OP_TICK;
            else if (w < 40) op = mfts_pkg::OP_CREATE;
            else if (w < 48) op = mfts_pkg::OP_WAIT_TIME;
            else if (w < 57) op = mfts_pkg::OP_WAIT_EVENT;
            else if (w < 68) op = mfts_pkg::OP_SET_EVENT;
            else if (w < 75) op = mfts_pkg::OP_CANCEL;
            else if (w < 80) op = mfts_pkg::OP_TEST_CANCEL;
            else if (w < 84) op = mfts_pkg::OP_EXIT;
            else if (w < 88) op = mfts_pkg::OP_RECLAIM;
            else if (w < 98) op = mfts_pkg::OP_READ;
            else             op = 4'($urandom_range(10, 15));
            amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            ev = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            if (no_idle)
                gap = 0;
            else if ($urandom_range(0, 9) < 8)
                gap = $urandom_range(0, 3);
            else
                gap = $urandom_range(4, 60);
            send_item(op, 4'($urandom), 2'($urandom), 1'($urandom), amt, ev, gap);
        end
    endtask

    // Results are sampled at the rising edge that ends the done cycle.
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result reported with no item outstanding");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.status, status);
                check_field("new_thread_id", e.new_thread_id, new_thread_id);
                check_field("running_valid", e.running_valid, running_valid);
                check_field("running_id", e.running_id, running_id);
                check_field("woken_valid", e.woken_valid, woken_valid);
                check_field("woken_id", e.woken_id, woken_id);
                check_field("slot_state", e.slot_state, slot_state);
                check_field("current_level", e.current_level, current_level);
                check_field("base_level", e.base_level, base_level);
                check_field("queued_ms", e.queued_ms, queued_ms);
                check_field("waited_ms", e.waited_ms, waited_ms);
            end
        end
    end

    // Main sequence: reset, directed tests, then random phases under
    // several timing settings including both extremes.
    initial
    begin
        int i;
        rst_n <= 1'b0;
        start <= 1'b0;
        opcode <= mfts_pkg::OP_TICK;
        thread_id <= '0;
        priority_req <= '0;
        defer_cancel <= 1'b0;
        wait_amount <= '0;
        event_num <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        wakes_seen = 0;
        creates_full = 0;
        q_high = mfts_pkg::QUANT_HIGH_RST;
        q_mid = mfts_pkg::QUANT_MID_RST;
        q_low = mfts_pkg::QUANT_LOW_RST;
        tick_len = mfts_pkg::TICK_MS_RST;
        order_ctr = '0;
        cpu_busy = 1'b0;
        cpu_slot = '0;
        for (i = 0; i < SLOTS; i++)
        begin
            t_used[i] = 1'b0;
            t_state[i] = mfts_pkg::TS_FREE;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_lifecycle();
        test_table_full();
        test_random_mix(250, 1'b0);
        test_random_mix(50, 1'b1);
        set_timing(1, 1, 1, 1000);           // every tick ends a quantum
        test_random_mix(300, 1'b0);
        set_timing(10000, 10000, 10000, 1);  // quanta almost never run out
        test_random_mix(300, 1'b0);
        set_timing(30, 50, 70, 10);
        test_random_mix(300, 1'b0);
        set_timing($urandom_range(1, 10000), $urandom_range(1, 10000),
                   $urandom_range(1, 10000), $urandom_range(1, 1000));
        test_random_mix(250, 1'b0);
        test_random_mix(50, 1'b1);
        set_timing(16383, 8191, 1, 1000);
        test_random_mix(150, 1'b0);
        drain();

        $display("Ran %0d items (%0d event wake-ups, %0d creates into a full table)",
                 items_sent, wakes_seen, creates_full);
        $display("over six timing settings, from one-tick quanta to very long ones.");
        if (errors == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/mfts_pkg.sv
src/mfts_ctrl.sv
src/mfts_dp.sv
src/multilevel_feedback_thread_scheduler_top.sv
tb/tb_multilevel_feedback_thread_scheduler_top.sv
